// ===== rtl/core/prf_pkg.sv =====
// Types and constants for the packet rule filter core.
// No dependencies; imported by packet_rule_filter_core.
`timescale 1ns / 1ps
`default_nettype none

package prf_pkg;

    // Protocol numbers the rules know about
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

    // Packet classes for the counters
    localparam logic [1:0] CLASS_TCP  = 2'd0;
    localparam logic [1:0] CLASS_UDP  = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;

    // Operation codes of an input item
    localparam logic OP_CLASSIFY   = 1'b0;
    localparam logic OP_WRITE_RULE = 1'b1;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_COUNT    = 2'd1;

    localparam int RULE_COUNT_W = 5;
    localparam int NUM_CLASSES  = 3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  protocol;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [3:0]  rule_slot;
    } req_item_t;

    typedef struct packed {
        logic        verdict;
        logic [3:0]  matched_slot;
        logic [1:0]  packet_class;
        logic [31:0] class_total;
        logic [31:0] class_drops;
    } rsp_item_t;

    // One entry of the rule store
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
    } rule_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_DROP,
        ST_DONE
    } prf_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/packet_rule_filter_core.sv =====
// Packet rule filter: first-match rule table scan with per-class counters.
// Depends on prf_pkg and prf_ram (rule store).
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  req     | in        | req_valid/req_stall | req_item  (operation, rule fields)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_item  (verdict, class counters)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A rule write goes from acceptance straight to the final state, which loads
//  the result register. A classify item with filtering on and a table of
//  N = min(rule_count, RULE_SLOTS) > 0 slots passes a count step, N reads
//  through the single read port of the rule store, a compare of the last
//  slot and a step that closes the scan before the result loads. A drop ends
//  the scan early through a step that bumps the drop counter. Filtering off
//  skips the scan; an empty table enters it and closes it at once. The next
//  item is taken once the sequencer is back in idle. Reset clears the counters,
//  the sequencer and the result valid; the rule store is not cleared. A stalled
//  result holds in the output register while the next item is taken; the
//  sequencer waits in its final state until the register is free.

module packet_rule_filter_core
    import prf_pkg::*;
#(
    parameter int RULE_SLOTS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire req_item_t              req_item,
    // result channel
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output rsp_item_t                   rsp_item,
    // configuration channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam int LIM_W  = (CNT_W > RULE_COUNT_W) ? CNT_W : RULE_COUNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                    filter_enable_reg;
    logic [RULE_COUNT_W-1:0] rule_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b1;
            rule_count_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                CFG_RULE_COUNT:    rule_count_reg    <= cfg_data[RULE_COUNT_W-1:0];
                default:           ;   // unmapped index: drop the write
            endcase
        end
    end

    // Clamp the scan length to the table depth
    logic [LIM_W-1:0] count_ext;
    logic [CNT_W-1:0] scan_limit;

    assign count_ext  = LIM_W'(rule_count_reg);
    assign scan_limit = (count_ext > LIM_W'(RULE_SLOTS)) ? CNT_W'(RULE_SLOTS)
                                                         : CNT_W'(count_ext);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    prf_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;          // next slot to read
    logic              cmp_pending_reg, cmp_pending_next;
    logic [SLOT_W-1:0] cmp_slot_reg, cmp_slot_next; // slot under compare
    logic              verdict_reg, verdict_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [31:0]       totals_reg [NUM_CLASSES];
    logic [31:0]       totals_next [NUM_CLASSES];
    logic [31:0]       drops_reg [NUM_CLASSES];
    logic [31:0]       drops_next [NUM_CLASSES];

    // Payload registers (no reset)
    req_item_t         pkt_reg;
    logic [1:0]        cls_reg;
    rsp_item_t         rsp_item_reg, rsp_item_next;

    logic              req_accept;
    logic [1:0]        pkt_cls;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;

    // Classify the incoming packet; anything not TCP or UDP counts as ICMP
    always_comb
    begin
        priority if (req_item.protocol == PROTO_NUM_TCP)
            pkt_cls = CLASS_TCP;
        else if (req_item.protocol == PROTO_NUM_UDP)
            pkt_cls = CLASS_UDP;
        else
            pkt_cls = CLASS_ICMP;
    end

    // ------------------------------------------------------------------
    // Rule store: write straight from an accepted write item, read one
    // slot per cycle during the scan
    // ------------------------------------------------------------------
    logic              rule_wr_en;
    rule_t             rule_wr_data;
    logic              rule_rd_en;
    rule_t             rule_rd_data;

    assign rule_wr_en = req_accept && (req_item.operation == OP_WRITE_RULE)
                        && (32'(req_item.rule_slot) < RULE_SLOTS);
    assign rule_wr_data.protocol     = req_item.protocol;
    assign rule_wr_data.dest_address = req_item.dest_address;
    assign rule_wr_data.dest_port    = req_item.dest_port;

    assign rule_rd_en = (state_reg == ST_SCAN) && (idx_reg < scan_limit);

    prf_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (rule_wr_en),
        .wr_addr (SLOT_W'(req_item.rule_slot)),
        .wr_data (rule_wr_data),
        .rd_en   (rule_rd_en),
        .rd_addr (idx_reg[SLOT_W-1:0]),
        .rd_data (rule_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared compare unit: does the rule just read drop the held packet?
    // ------------------------------------------------------------------
    logic rule_match;
    logic rule_drop;

    assign rule_match = (rule_rd_data.protocol == pkt_reg.protocol)
                        && (rule_rd_data.dest_address == pkt_reg.dest_address);

    always_comb
    begin
        if (!rule_match)
            rule_drop = 1'b0;
        else if ((rule_rd_data.protocol == PROTO_NUM_TCP)
                 || (rule_rd_data.protocol == PROTO_NUM_UDP))
            rule_drop = (rule_rd_data.dest_port == pkt_reg.dest_port);
        else
            rule_drop = (rule_rd_data.protocol == PROTO_NUM_ICMP);
    end

    // ------------------------------------------------------------------
    // Shared incrementer: bumps the class total, then the drop counter
    // ------------------------------------------------------------------
    logic [31:0] sel_total;
    logic [31:0] sel_drops;
    logic [31:0] inc_sum;

    assign sel_total = totals_reg[cls_reg];
    assign sel_drops = drops_reg[cls_reg];
    assign inc_sum   = ((state_reg == ST_DROP) ? sel_drops : sel_total) + 32'd1;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmp_pending_next = 1'b0;
        cmp_slot_next    = cmp_slot_reg;
        verdict_next     = verdict_reg;
        hit_slot_next    = hit_slot_reg;
        totals_next      = totals_reg;
        drops_next       = drops_reg;
        rsp_item_next    = rsp_item_reg;

        // Release the result register once the far side takes it
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    verdict_next  = 1'b0;
                    hit_slot_next = '0;
                    if (req_item.operation == OP_WRITE_RULE)
                        state_next = ST_DONE;
                    else
                        state_next = ST_COUNT;
                end
            end

            ST_COUNT:
            begin
                totals_next[cls_reg] = inc_sum;
                idx_next             = '0;
                state_next           = filter_enable_reg ? ST_SCAN : ST_DONE;
            end

            ST_SCAN:
            begin
                // Issue the next read while comparing the previous slot
                cmp_pending_next = rule_rd_en;
                cmp_slot_next    = idx_reg[SLOT_W-1:0];
                if (rule_rd_en)
                    idx_next = idx_reg + CNT_W'(1);

                priority if (cmp_pending_reg && rule_drop)
                begin
                    verdict_next  = 1'b1;
                    hit_slot_next = cmp_slot_reg;
                    state_next    = ST_DROP;
                end
                else if (!cmp_pending_reg && !rule_rd_en)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DROP:
            begin
                drops_next[cls_reg] = inc_sum;
                state_next          = ST_DONE;
            end

            ST_DONE:
            begin
                // Wait for a free result register, then load it
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (pkt_reg.operation == OP_WRITE_RULE)
                    begin
                        rsp_item_next = '0;
                    end
                    else
                    begin
                        rsp_item_next.verdict      = verdict_reg;
                        rsp_item_next.matched_slot = 4'(hit_slot_reg);
                        rsp_item_next.packet_class = cls_reg;
                        rsp_item_next.class_total  = sel_total;
                        rsp_item_next.class_drops  = sel_drops;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            cmp_pending_reg <= 1'b0;
            verdict_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                totals_reg[c] <= '0;
                drops_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cmp_pending_reg <= cmp_pending_next;
            verdict_reg     <= verdict_next;
            rsp_valid_reg   <= rsp_valid_next;
            totals_reg      <= totals_next;
            drops_reg       <= drops_next;
        end
    end

    // Payload registers: hold the accepted item and the pending result
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            pkt_reg <= req_item;
            cls_reg <= pkt_cls;
        end
        cmp_slot_reg <= cmp_slot_next;
        hit_slot_reg <= hit_slot_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A compare in flight only ever belongs to a running scan
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_pending_reg |-> (state_reg == ST_SCAN || state_reg == ST_DROP))
        else $error("rule compare pending outside the scan");

    // The count step advances the class total by exactly one
    a_total_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |=> (sel_total == $past(inc_sum)))
        else $error("class total not advanced by the count step");

    // A dropped packet reports a slot that lies inside the table
    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.verdict) |-> (32'(rsp_item.matched_slot) < RULE_SLOTS))
        else $error("drop verdict with slot outside the rule table");

    // Only the three defined classes reach the result
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.packet_class == CLASS_TCP
                       || rsp_item.packet_class == CLASS_UDP
                       || rsp_item.packet_class == CLASS_ICMP))
        else $error("undefined packet class in result");

endmodule

`default_nettype wire

// ===== rtl/core/prf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the rule table of the packet rule filter.
`timescale 1ns / 1ps
`default_nettype none

module prf_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]              wr_data,
    input  wire logic                          rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
